/* rtl/core/xdau_pkg.sv */
// ----------------------------------------------------------------------------
// xdau_pkg
// Shared types, opcodes, flag positions and arithmetic helpers of the x86
// decimal adjust unit.
// ----------------------------------------------------------------------------
package xdau_pkg;

  // Instruction selector codes
  localparam logic [2:0] OP_DAA = 3'd0;
  localparam logic [2:0] OP_DAS = 3'd1;
  localparam logic [2:0] OP_AAA = 3'd2;
  localparam logic [2:0] OP_AAS = 3'd3;
  localparam logic [2:0] OP_AAM = 3'd4;
  localparam logic [2:0] OP_AAD = 3'd5;

  // 8086 flag bit positions
  localparam int unsigned FL_CF = 0;
  localparam int unsigned FL_PF = 2;
  localparam int unsigned FL_AF = 4;
  localparam int unsigned FL_ZF = 6;
  localparam int unsigned FL_SF = 7;
  localparam int unsigned FL_OF = 11;

  localparam logic [7:0] HIGH_LIMIT_AF = 8'h9F;
  localparam logic [7:0] HIGH_LIMIT    = 8'h99;
  localparam logic [7:0] LOW_FIX       = 8'h06;
  localparam logic [7:0] HIGH_FIX      = 8'h60;
  localparam logic [7:0] NIBBLE_MASK   = 8'h0F;
  localparam logic [3:0] NIBBLE_MAX    = 4'd9;

  typedef struct packed {
    logic [7:0]  r;
    logic [15:0] flags;
  } alu_res_t;

  typedef struct packed {
    logic [7:0] rem;   // partial remainder
    logic [7:0] work;  // dividend bits still to go, quotient bits shifted in
  } div_state_t;

  // Payload carried down the pipe
  typedef struct packed {
    logic [2:0]  op;
    logic [15:0] ax;
    logic [7:0]  imm;
    logic [15:0] flags;
    logic        low_fix;
    logic        high_fix;
    logic [7:0]  prod;
    div_state_t  div;
  } stage_t;

  // SF, ZF and PF from an 8-bit result
  function automatic logic [15:0] result_flags(input logic [15:0] f, input logic [7:0] r);
    logic [15:0] o;
    o        = f;
    o[FL_SF] = r[7];
    o[FL_ZF] = (r == 8'h00);
    o[FL_PF] = ~^r;
    return o;
  endfunction

  // 8-bit add or subtract with full arithmetic flags
  function automatic alu_res_t alu8(input logic sub, input logic [7:0] a,
                                    input logic [7:0] b, input logic [15:0] f);
    logic [8:0]  s;
    logic [15:0] o;
    alu_res_t    res;
    o = f;
    if (sub) begin
      s        = {1'b0, a} - {1'b0, b};
      o[FL_OF] = ((a ^ b) & (a ^ s[7:0])) >> 7 != 8'h00;
    end else begin
      s        = {1'b0, a} + {1'b0, b};
      o[FL_OF] = (~(a ^ b) & (a ^ s[7:0])) >> 7 != 8'h00;
    end
    o[FL_CF]  = s[8];
    o[FL_AF]  = a[4] ^ b[4] ^ s[4];
    res.r     = s[7:0];
    res.flags = result_flags(o, s[7:0]);
    return res;
  endfunction

  // One restoring division step
  function automatic div_state_t div_step(input div_state_t d, input logic [7:0] divisor);
    logic [8:0] t;
    logic [8:0] diff;
    logic       ge;
    div_state_t o;
    t      = {d.rem, d.work[7]};
    diff   = t - {1'b0, divisor};
    ge     = (t >= {1'b0, divisor});
    o.rem  = ge ? diff[7:0] : t[7:0];
    o.work = {d.work[6:0], ge};
    return o;
  endfunction

endpackage

/* rtl/core/x86_decimal_adjust_unit_core.sv */
// ----------------------------------------------------------------------------
// x86_decimal_adjust_unit_core
// Executes DAA, DAS, AAA, AAS, AAM and AAD on AX and the flags word.
//
// One instruction is taken per clock: start is sampled every cycle and busy
// is always low. Each request's result is registered in the out stage after
// passing s1 to s5. It then sits on the ports for one cycle with done high.
// Results are in request order and the receiver cannot stall them, so it
// must take each one when done is high. The AAM divide is a restoring
// divider that resolves two quotient bits per stage over four stages. A zero
// AAM divisor leaves AX unchanged, sets ZF and PF, clears CF, AF, OF and SF
// and raises divide_error alongside done.
// ----------------------------------------------------------------------------
module x86_decimal_adjust_unit_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  operation,
  input  logic [15:0] ax_in,
  input  logic [7:0]  imm_byte,
  input  logic [15:0] flags_in,
  output logic        done,
  output logic [15:0] ax_out,
  output logic [15:0] flags_out,
  output logic        divide_error
);

  // Stage layout
  //   s1: captured request
  //   s2: fix decisions, AAD product, quotient bits 7..6
  //   s3: adjust/AAD add done, quotient bits 5..4
  //   s4: quotient bits 3..2
  //   s5: quotient bits 1..0
  //   out: AAM flags folded in, result registered
  logic                 v1, v2, v3, v4, v5;
  xdau_pkg::stage_t     s1, s2, s3, s4, s5;
  xdau_pkg::stage_t     s2_next, s3_next, s4_next, s5_next;
  logic [15:0]          ax_next;
  logic [15:0]          flags_next;
  logic                 err_next;

  assign busy = 1'b0;  // fully pipelined, never holds off a request

  // ---- s1 -> s2: decide fixes, start multiply and divide -------------------
  always_comb begin
    logic [7:0]  al;
    logic [15:0] prod16;
    xdau_pkg::div_state_t d;
    al               = s1.ax[7:0];
    s2_next          = s1;
    s2_next.low_fix  = (al[3:0] > xdau_pkg::NIBBLE_MAX) || s1.flags[xdau_pkg::FL_AF];
    s2_next.high_fix = s1.flags[xdau_pkg::FL_CF] ||
                       (al > (s1.flags[xdau_pkg::FL_AF] ? xdau_pkg::HIGH_LIMIT_AF
                                                        : xdau_pkg::HIGH_LIMIT));
    prod16           = s1.ax[15:8] * s1.imm;
    s2_next.prod     = prod16[7:0];
    d.rem            = 8'h00;
    d.work           = al;
    d                = xdau_pkg::div_step(d, s1.imm);
    s2_next.div      = xdau_pkg::div_step(d, s1.imm);
  end

  // ---- s2 -> s3: adjust and AAD arithmetic, divide bits 5..4 --------------
  always_comb begin
    logic [7:0]         al;
    logic [7:0]         ah;
    logic [7:0]         corr;
    logic               sub;
    xdau_pkg::alu_res_t res;
    al      = s2.ax[7:0];
    ah      = s2.ax[15:8];
    s3_next = s2;
    s3_next.div = xdau_pkg::div_step(xdau_pkg::div_step(s2.div, s2.imm), s2.imm);
    corr    = (s2.low_fix  ? xdau_pkg::LOW_FIX  : 8'h00) |
              (s2.high_fix ? xdau_pkg::HIGH_FIX : 8'h00);
    sub     = (s2.op == xdau_pkg::OP_DAS) || (s2.op == xdau_pkg::OP_AAS);
    res     = '0;
    case (s2.op)
      xdau_pkg::OP_DAA, xdau_pkg::OP_DAS: begin
        res = xdau_pkg::alu8(sub, al, corr, s2.flags);
        res.flags[xdau_pkg::FL_CF] = s2.high_fix;
        res.flags[xdau_pkg::FL_AF] = s2.low_fix;
        s3_next.ax    = {ah, res.r};
        s3_next.flags = res.flags;
      end
      xdau_pkg::OP_AAA, xdau_pkg::OP_AAS: begin
        res = xdau_pkg::alu8(sub, al, s2.low_fix ? xdau_pkg::LOW_FIX : 8'h00, s2.flags);
        res.flags[xdau_pkg::FL_CF] = s2.low_fix;
        res.flags[xdau_pkg::FL_AF] = s2.low_fix;
        if (s2.low_fix) begin
          ah = sub ? (ah - 8'd1) : (ah + 8'd1);
        end
        s3_next.ax    = {ah, res.r & xdau_pkg::NIBBLE_MASK};
        s3_next.flags = res.flags;
      end
      xdau_pkg::OP_AAD: begin
        res = xdau_pkg::alu8(1'b0, s2.prod, al, s2.flags);
        s3_next.ax    = {8'h00, res.r};
        s3_next.flags = res.flags;
      end
      default: begin
        // AAM finishes at the end; undefined selectors pass through
      end
    endcase
  end

  // ---- s3 -> s4 and s4 -> s5: remaining quotient bits ----------------------
  always_comb begin
    s4_next     = s3;
    s4_next.div = xdau_pkg::div_step(xdau_pkg::div_step(s3.div, s3.imm), s3.imm);
    s5_next     = s4;
    s5_next.div = xdau_pkg::div_step(xdau_pkg::div_step(s4.div, s4.imm), s4.imm);
  end

  // ---- s5 -> out: AAM result and flags ------------------------------------
  always_comb begin
    logic [15:0] f;
    ax_next    = s5.ax;
    flags_next = s5.flags;
    err_next   = 1'b0;
    f          = s5.flags;
    if (s5.op == xdau_pkg::OP_AAM) begin
      f[xdau_pkg::FL_CF] = 1'b0;
      f[xdau_pkg::FL_AF] = 1'b0;
      f[xdau_pkg::FL_OF] = 1'b0;
      if (s5.imm == 8'h00) begin
        flags_next = xdau_pkg::result_flags(f, 8'h00);
        err_next   = 1'b1;
      end else begin
        flags_next = xdau_pkg::result_flags(f, s5.div.rem);
        ax_next    = {s5.div.work, s5.div.rem};
      end
    end
  end

  // ---- valid chain ---------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      v4   <= 1'b0;
      v5   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= start && !busy;
      v2   <= v1;
      v3   <= v2;
      v4   <= v3;
      v5   <= v4;
      done <= v5;
    end
  end

  // ---- payload -------------------------------------------------------------
  always_ff @(posedge clk) begin
    s1.op       <= operation;
    s1.ax       <= ax_in;
    s1.imm      <= imm_byte;
    s1.flags    <= flags_in;
    s1.low_fix  <= 1'b0;
    s1.high_fix <= 1'b0;
    s1.prod     <= 8'h00;
    s1.div      <= '0;
    s2          <= s2_next;
    s3          <= s3_next;
    s4          <= s4_next;
    s5          <= s5_next;
    ax_out      <= ax_next;
    flags_out   <= flags_next;
  end

  // error mark only ever shows with a result
  always_ff @(posedge clk) begin
    if (rst) begin
      divide_error <= 1'b0;
    end else begin
      divide_error <= v5 && err_next;
    end
  end

  // ---- assertions ----------------------------------------------------------
  a_fixed_latency : assert property (@(posedge clk) disable iff (rst)
    start |-> ##6 done)
    else $error("request did not complete after six cycles");

  a_err_with_done : assert property (@(posedge clk) disable iff (rst)
    divide_error |-> done)
    else $error("divide_error without a result");

  a_err_flags : assert property (@(posedge clk) disable iff (rst)
    (done && divide_error) |-> (flags_out[xdau_pkg::FL_ZF] && flags_out[xdau_pkg::FL_PF] &&
                                !flags_out[xdau_pkg::FL_CF] && !flags_out[xdau_pkg::FL_SF]))
    else $error("zero-divisor AAM flags wrong");

endmodule
